@@ hdl/stc_pkg.sv @@
// Shared types, the scancode table and constants for the scancode text writer.
`timescale 1ns / 1ps

package stc_pkg;

	localparam int unsigned CODE_W   = 8;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned ATTR_W   = 8;
	localparam int unsigned COL_W    = 7;
	localparam int unsigned ROW_W    = 5;
	localparam int unsigned INDEX_W  = 11;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned TABLE_AW = 6;

	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] NO_CHAR      = 8'h00;

	// Unshifted set-1 make codes 0..57; codes 58..63 padded with no character
	localparam logic [CHAR_W-1:0] KEY_TABLE [0:(1 << TABLE_AW)-1] = '{
		8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic              write;
		logic              newline;
		logic [CHAR_W-1:0] ascii;
	} key_event_t;

endpackage

@@ hdl/stc_key_map.sv @@
// Scancode decoder: release filter, table lookup, newline and write flags.
`timescale 1ns / 1ps

module stc_key_map (
	input  logic [stc_pkg::CODE_W-1:0] scancode,
	output stc_pkg::key_event_t        ev
);

	logic [stc_pkg::CHAR_W-1:0] ascii;

	// Release bit or code 64 and up falls outside the table
	always_comb begin
		if (scancode[stc_pkg::CODE_W-1:stc_pkg::TABLE_AW] == '0) begin
			ascii = stc_pkg::KEY_TABLE[scancode[stc_pkg::TABLE_AW-1:0]];
		end else begin
			ascii = stc_pkg::NO_CHAR;
		end
	end

	assign ev.ascii   = ascii;
	assign ev.newline = (ascii == stc_pkg::NEWLINE_CHAR);
	assign ev.write   = (ascii != stc_pkg::NO_CHAR) && (ascii != stc_pkg::NEWLINE_CHAR);

endmodule

@@ hdl/stc_cursor.sv @@
// Cursor row and column registers with wrap logic and the cell address.
`timescale 1ns / 1ps

module stc_cursor #(
	parameter int unsigned SCREEN_COLUMNS = 80,
	parameter int unsigned SCREEN_ROWS    = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  stc_pkg::key_event_t          ev,
	output logic [stc_pkg::INDEX_W-1:0]  cell_index
);

	localparam int unsigned PROD_W = stc_pkg::ROW_W + stc_pkg::COL_W + 1;
	localparam logic [stc_pkg::COL_W:0] COLS = (stc_pkg::COL_W + 1)'(SCREEN_COLUMNS);
	localparam logic [stc_pkg::ROW_W:0] ROWS = (stc_pkg::ROW_W + 1)'(SCREEN_ROWS);

	logic [stc_pkg::COL_W-1:0] col_q;
	logic [stc_pkg::ROW_W-1:0] row_q;
	logic [stc_pkg::COL_W:0]   col_inc;
	logic [stc_pkg::ROW_W:0]   row_inc;
	logic                      row_adv;
	logic [stc_pkg::COL_W-1:0] col_nxt;
	logic [stc_pkg::ROW_W-1:0] row_nxt;
	logic [PROD_W-1:0]         addr;

	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;

	always_comb begin
		col_nxt = col_q;
		row_adv = 1'b0;
		if (ev.newline) begin
			col_nxt = '0;
			row_adv = 1'b1;
		end else if (ev.write) begin
			if (col_inc >= COLS) begin
				col_nxt = '0;
				row_adv = 1'b1;
			end else begin
				col_nxt = col_inc[stc_pkg::COL_W-1:0];
			end
		end
		row_nxt = row_q;
		if (row_adv) begin
			row_nxt = (row_inc >= ROWS) ? '0 : row_inc[stc_pkg::ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	assign addr = PROD_W'(row_q) * PROD_W'(COLS) + PROD_W'(col_q);
	assign cell_index = addr[stc_pkg::INDEX_W-1:0];

endmodule

@@ hdl/scancode_text_cursor_writer.sv @@
// Top level: scancode stream in, text cell writes out.
`timescale 1ns / 1ps

// Takes one set-1 scancode per beat and emits at most one text cell write per
// beat. Releases, unmapped codes and newline produce no output beat; newline
// only moves the cursor to the start of the next row. A written cell carries
// the attribute register in bits 15:8 and the ASCII code in bits 7:0, at
// address row*SCREEN_COLUMNS+column (low 11 bits). Column wraps into the next
// row, the last row wraps to row 0; there is no scrolling. Throughput is one
// scancode per clock while the output is not stalled: a beat is held in the
// input register, the table lookup and cursor update run from that register,
// and the result lands in the output register once it drains or is empty. A
// stall on m_axis_tready holds the input register and the cursor.
// The attribute register resets to 0x0F and should be written while idle.
module scancode_text_cursor_writer #(
	parameter int unsigned SCREEN_COLUMNS = 80,
	parameter int unsigned SCREEN_ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,    // text_attribute
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] scancode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [10:0] cell_index, [26:11] cell_word, [31:27] zero
);

	localparam int unsigned OUT_W = stc_pkg::INDEX_W + stc_pkg::WORD_W;

	logic [stc_pkg::ATTR_W-1:0]  attr_q;
	logic                        valid_s1;
	logic [stc_pkg::CODE_W-1:0]  code_s1;
	logic                        out_valid_q;
	logic [stc_pkg::INDEX_W-1:0] index_q;
	logic [stc_pkg::WORD_W-1:0]  word_q;
	logic                        advance;
	logic                        step;
	stc_pkg::key_event_t         ev;
	logic [stc_pkg::INDEX_W-1:0] cell_index;

	// Output register drains or is empty
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= stc_pkg::ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			code_s1 <= s_axis_tdata;
		end
	end

	stc_key_map u_key_map (
		.scancode (code_s1),
		.ev       (ev)
	);

	stc_cursor #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.ev         (ev),
		.cell_index (cell_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && ev.write;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ev.write) begin
			index_q <= cell_index;
			word_q  <= {attr_q, ev.ascii};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(32 - OUT_W)'(0), word_q, index_q};

endmodule
